>>> src/kss_pkg.sv
// ----------------------------------------------------------------------------
// kss_pkg
// Shared types and constants for the order-statistic selection block.
// ----------------------------------------------------------------------------
package kss_pkg;

  localparam int MAX_ELEMENTS = 1024;
  localparam int IDX_W        = $clog2(MAX_ELEMENTS);
  localparam int CNT_W        = IDX_W + 1;
  localparam int VAL_W        = 32;
  localparam int RANK_W       = 10;
  localparam int LFSR_W       = 16;
  localparam int PROD_W       = LFSR_W + CNT_W;
  localparam int CMP_W        = RANK_W + CNT_W;
  localparam int SHORT_RANGE  = 10;

  localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;
  localparam logic [LFSR_W-1:0] LFSR_MASK = 16'hB400;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic [RANK_W-1:0]       rank;
    logic                    is_last;
  } kss_in_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] selected;
    logic                    rank_error;
  } kss_out_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] addr;
    logic [VAL_W-1:0] data;
  } kss_load_t;

  typedef struct packed {
    logic              go;
    logic [RANK_W-1:0] rank;
    logic [CNT_W-1:0]  count;
  } kss_start_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ROUND,
    ST_PICK,
    ST_PIVRD,
    ST_PIVWR,
    ST_SCANRD,
    ST_SCANEV,
    ST_SCANWR,
    ST_FINRD,
    ST_FINWR1,
    ST_FINWR2,
    ST_LASTRD,
    ST_LASTEV,
    ST_DONE
  } kss_state_e;

endpackage

>>> src/kth_smallest_select.sv
// ----------------------------------------------------------------------------
// kth_smallest_select
// Loads a set of signed 32-bit values and returns its k-th smallest element.
// ----------------------------------------------------------------------------
// Input channel: one transaction per element; the transaction with is_last
// set carries the zero-based rank and starts the selection. Elements past
// the store depth are dropped; a final transaction then still selects over
// the elements held.
// Loading accepts an element on every transaction. After the final element
// the input stalls while quickselect runs and until its result is taken:
// each round picks a pivot, then reads and evaluates each scanned element,
// with one more write when it moves left of the pivot, all paced by the
// single write port of the element memory. A rank at or beyond the element
// count returns rank_error with selected zero, without any round.
// Output channel: one transaction per set, held in an output register; a
// stalled result keeps its payload, and loading of the next set proceeds
// meanwhile. Reset empties the set and seeds the pivot generator; the
// element memory needs no clearing.
// ----------------------------------------------------------------------------
module kth_smallest_select
  import kss_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  kss_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output kss_out_t out_data_o
);

  logic [CNT_W-1:0] count_q, count_d;
  logic             out_valid_q, out_valid_d;
  kss_out_t         out_q, out_d;

  logic             in_fire;
  logic             has_room;
  logic [CNT_W-1:0] count_new;
  logic             busy;
  logic             res_valid;
  logic             res_ready;
  kss_out_t         res;
  kss_load_t        load;
  kss_start_t       start;

  assign in_fire   = in_valid_i && !in_stall_o;
  assign has_room  = count_q < CNT_W'(MAX_ELEMENTS);
  assign count_new = has_room ? count_q + CNT_W'(1) : count_q;
  assign res_ready = !out_valid_q || !out_stall_i;

  assign load  = '{we: in_fire && has_room, addr: count_q[IDX_W-1:0],
                   data: in_data_i.value};
  assign start = '{go: in_fire && in_data_i.is_last, rank: in_data_i.rank,
                   count: count_new};

  kss_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .start_i     (start),
    .busy_o      (busy),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  always_comb begin
    count_d     = count_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (in_fire) begin
      count_d = in_data_i.is_last ? '0 : count_new;
    end
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
      out_d       = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign in_stall_o  = busy;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> src/kss_store.sv
// ----------------------------------------------------------------------------
// kss_store
// Element memory: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module kss_store
  import kss_pkg::*;
(
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [IDX_W-1:0] waddr_i,
  input  logic [VAL_W-1:0] wdata_i,
  input  logic [IDX_W-1:0] raddr_a_i,
  input  logic [IDX_W-1:0] raddr_b_i,
  output logic [VAL_W-1:0] rdata_a_o,
  output logic [VAL_W-1:0] rdata_b_o
);

  logic [VAL_W-1:0] mem [MAX_ELEMENTS];
  logic [VAL_W-1:0] rdata_a_q;
  logic [VAL_W-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_a_q <= mem[raddr_a_i];
    rdata_b_q <= mem[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

>>> src/kss_engine.sv
// ----------------------------------------------------------------------------
// kss_engine
// Quickselect sequencer: partitions the stored range in place around a pivot
// and narrows toward the wanted rank, one memory access step per cycle.
// ----------------------------------------------------------------------------
module kss_engine
  import kss_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  kss_load_t  load_i,
  input  kss_start_t start_i,
  output logic       busy_o,
  output logic       res_valid_o,
  input  logic       res_ready_i,
  output kss_out_t   res_o
);

  kss_state_e state_q, state_d;

  logic [IDX_W-1:0]  low_q, low_d;
  logic [CNT_W-1:0]  high_q, high_d;
  logic [RANK_W-1:0] target_q, target_d;
  logic [LFSR_W-1:0] lfsr_q, lfsr_d;
  logic [PROD_W-1:0] prod_q, prod_d;
  logic [IDX_W-1:0]  p_q, p_d;
  logic [VAL_W-1:0]  pivot_q, pivot_d;
  logic [VAL_W-1:0]  tmp_q, tmp_d;
  logic [IDX_W-1:0]  i_q, i_d;
  logic [IDX_W-1:0]  lt_q, lt_d;
  kss_out_t          res_q, res_d;

  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic [VAL_W-1:0]  mem_wdata;
  logic [IDX_W-1:0]  raddr_a;
  logic [IDX_W-1:0]  raddr_b;
  logic [VAL_W-1:0]  rdata_a;
  logic [VAL_W-1:0]  rdata_b;

  logic [CNT_W-1:0]  len;
  logic [CNT_W-1:0]  offset;
  logic [LFSR_W-1:0] lfsr_next;
  logic [CNT_W-1:0]  i_next;
  logic [CMP_W-1:0]  lt_ext;
  logic [CMP_W-1:0]  target_ext;
  logic              start_err;

  kss_store u_store (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .waddr_i   (mem_waddr),
    .wdata_i   (mem_wdata),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  assign len        = high_q - {1'b0, low_q};
  assign offset     = prod_q[PROD_W-1:LFSR_W];
  assign lfsr_next  = (lfsr_q >> 1) ^ (lfsr_q[0] ? LFSR_MASK : '0);
  assign i_next     = {1'b0, i_q} + CNT_W'(1);
  assign lt_ext     = CMP_W'(lt_q);
  assign target_ext = CMP_W'(target_q);
  assign start_err  = CMP_W'(start_i.rank) >= CMP_W'(start_i.count);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      low_q    <= '0;
      high_q   <= '0;
      target_q <= '0;
      lfsr_q   <= LFSR_SEED;
    end else begin
      state_q  <= state_d;
      low_q    <= low_d;
      high_q   <= high_d;
      target_q <= target_d;
      lfsr_q   <= lfsr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q  <= prod_d;
    p_q     <= p_d;
    pivot_q <= pivot_d;
    tmp_q   <= tmp_d;
    i_q     <= i_d;
    lt_q    <= lt_d;
    res_q   <= res_d;
  end

  always_comb begin
    state_d   = state_q;
    low_d     = low_q;
    high_d    = high_q;
    target_d  = target_q;
    lfsr_d    = lfsr_q;
    prod_d    = prod_q;
    p_d       = p_q;
    pivot_d   = pivot_q;
    tmp_d     = tmp_q;
    i_d       = i_q;
    lt_d      = lt_q;
    res_d     = res_q;
    mem_we    = 1'b0;
    mem_waddr = load_i.addr;
    mem_wdata = load_i.data;
    raddr_a   = i_q;
    raddr_b   = low_q;

    case (state_q)
      ST_IDLE: begin
        mem_we = load_i.we;
        if (start_i.go) begin
          target_d = start_i.rank;
          low_d    = '0;
          high_d   = start_i.count;
          if (start_err) begin
            res_d   = '{selected: '0, rank_error: 1'b1};
            state_d = ST_DONE;
          end else begin
            state_d = ST_ROUND;
          end
        end
      end
      ST_ROUND: begin
        if (len <= CNT_W'(1)) begin
          state_d = ST_LASTRD;
        end else if (len > CNT_W'(SHORT_RANGE)) begin
          lfsr_d  = lfsr_next;
          state_d = ST_PICK;
        end else begin
          prod_d  = '0;
          state_d = ST_PICK;
        end
      end
      ST_PICK: begin
        // scaled lfsr gives an offset below the range length
        if (len > CNT_W'(SHORT_RANGE)) begin
          prod_d = PROD_W'(lfsr_q) * PROD_W'(len);
        end else begin
          prod_d = '0;
        end
        state_d = ST_PIVRD;
      end
      ST_PIVRD: begin
        p_d     = low_q + offset[IDX_W-1:0];
        raddr_a = low_q + offset[IDX_W-1:0];
        raddr_b = low_q;
        state_d = ST_PIVWR;
      end
      ST_PIVWR: begin
        // pivot lives in a register; its slot at low is rewritten at the end
        pivot_d   = rdata_a;
        mem_we    = 1'b1;
        mem_waddr = p_q;
        mem_wdata = rdata_b;
        i_d       = low_q + IDX_W'(1);
        lt_d      = low_q;
        state_d   = ST_SCANRD;
      end
      ST_SCANRD: begin
        raddr_a = i_q;
        raddr_b = lt_q + IDX_W'(1);
        state_d = ST_SCANEV;
      end
      ST_SCANEV: begin
        if ($signed(rdata_a) < $signed(pivot_q)) begin
          mem_we    = 1'b1;
          mem_waddr = lt_q + IDX_W'(1);
          mem_wdata = rdata_a;
          tmp_d     = rdata_b;
          lt_d      = lt_q + IDX_W'(1);
          state_d   = ST_SCANWR;
        end else if (i_next == high_q) begin
          state_d = ST_FINRD;
        end else begin
          i_d     = i_next[IDX_W-1:0];
          state_d = ST_SCANRD;
        end
      end
      ST_SCANWR: begin
        mem_we    = 1'b1;
        mem_waddr = i_q;
        mem_wdata = tmp_q;
        if (i_next == high_q) begin
          state_d = ST_FINRD;
        end else begin
          i_d     = i_next[IDX_W-1:0];
          state_d = ST_SCANRD;
        end
      end
      ST_FINRD: begin
        raddr_a = lt_q;
        state_d = ST_FINWR1;
      end
      ST_FINWR1: begin
        mem_we    = 1'b1;
        mem_waddr = low_q;
        mem_wdata = rdata_a;
        state_d   = ST_FINWR2;
      end
      ST_FINWR2: begin
        mem_we    = 1'b1;
        mem_waddr = lt_q;
        mem_wdata = pivot_q;
        if (lt_ext == target_ext) begin
          res_d   = '{selected: pivot_q, rank_error: 1'b0};
          state_d = ST_DONE;
        end else if (target_ext < lt_ext) begin
          high_d  = CNT_W'(lt_q);
          state_d = ST_ROUND;
        end else begin
          low_d   = lt_q + IDX_W'(1);
          state_d = ST_ROUND;
        end
      end
      ST_LASTRD: begin
        raddr_a = low_q;
        state_d = ST_LASTEV;
      end
      ST_LASTEV: begin
        res_d   = '{selected: rdata_a, rank_error: 1'b0};
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy_o      = (state_q != ST_IDLE);
  assign res_valid_o = (state_q == ST_DONE);
  assign res_o       = res_q;

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i.go |-> state_q == ST_IDLE)
    else $error("selection started while busy");

  a_round_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_ROUND |->
      CMP_W'(low_q) <= target_ext && target_ext < CMP_W'(high_q))
    else $error("target rank left the active range");

  a_scan_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SCANRD |-> lt_q < i_q && CNT_W'(i_q) < high_q)
    else $error("partition indices out of order");

  a_pivot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_PIVWR |-> p_q >= low_q && CNT_W'(p_q) < high_q)
    else $error("pivot outside active range");

endmodule
